// ===== rtl/core/iidl_pkg.sv =====
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared types and constants for the indexed insert/delete list: command and
// status codes, word type and the control bundle broadcast to the cell chain.
// ----------------------------------------------------------------------------
package iidl_pkg;

   // field widths fixed by the interface
   localparam int CMD_W     = 3;
   localparam int POS_W     = 7;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 7;
   localparam int STATUS_W  = 2;

   // default list depth
   localparam int DEPTH_DEF = 64;

   // read value for an out-of-range read
   localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef logic signed [VALUE_W-1:0] word_type;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_READ   = 3'd2,
      CMD_PUSH   = 3'd3,
      CMD_POP    = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // what every cell does this cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      word_type    value;
   } cell_ctl_type;

endpackage

// ===== rtl/core/iidl_cell.sv =====
// ----------------------------------------------------------------------------
// iidl_cell
// One slot of the list. Holds its word, loads the new word, takes the word of
// its lower neighbor on an insert or of its upper neighbor on a remove.
// ----------------------------------------------------------------------------
module iidl_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  iidl_pkg::cell_ctl_type ctl,
   input  logic [CNT_W-1:0]       at_idx,
   input  logic [CNT_W-1:0]       cnt,
   input  iidl_pkg::word_type     left_word,
   input  iidl_pkg::word_type     right_word,
   output iidl_pkg::word_type     word_out
);
   import iidl_pkg::*;

   localparam logic [CNT_W-1:0] SLOT      = CNT_W'(INDEX);
   localparam logic [CNT_W:0]   SLOT_NEXT = (CNT_W+1)'(INDEX + 1);

   word_type word_ff;
   word_type word_in;

   // next word of this slot
   always_comb begin
      word_in = word_ff;
      unique case (ctl.op)
         OP_INSERT: begin
            if (SLOT == at_idx) begin
               word_in = ctl.value;
            end else if (SLOT > at_idx && SLOT <= cnt) begin
               word_in = left_word;
            end
         end
         OP_REMOVE: begin
            if (SLOT >= at_idx && SLOT_NEXT < {1'b0, cnt}) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

// ===== rtl/core/indexed_insert_delete_list.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Ordered list of signed words held in a chain of cells; insert and remove
// shift every later entry by one place at once.
//
//   channel | direction | ports                                   | beat
//   req     | in        | req_valid, req_stall, cmd/position/value | one command
//   rsp     | out       | rsp_valid, rsp_stall, five result fields  | one result
//
// An accepted command updates the cell chain and the pending stage at the
// accepting edge; once the output register is free, the pending stage selects
// the read, first and last entries from the cells into the output register.
// One command is accepted per cycle while results drain.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled result holds and backs up at most one command behind it.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list #(
   parameter int DEPTH = iidl_pkg::DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [iidl_pkg::CMD_W-1:0]     req_cmd,
   input  logic [iidl_pkg::POS_W-1:0]     req_position,
   input  logic signed [iidl_pkg::VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [iidl_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [iidl_pkg::COUNT_W-1:0]   rsp_count,
   output logic signed [iidl_pkg::VALUE_W-1:0] rsp_first_entry,
   output logic signed [iidl_pkg::VALUE_W-1:0] rsp_last_entry,
   output logic [iidl_pkg::STATUS_W-1:0]  rsp_status
);
   import iidl_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   typedef enum logic [1:0] {
      RD_ZERO = 2'd0,
      RD_WORD = 2'd1,
      RD_MIN  = 2'd2
   } rd_sel_type;

   // list state
   logic [CW-1:0] count_ff, count_in;
   word_type      words [DEPTH];
   cell_ctl_type  cell_ctl;
   logic [CW-1:0] at_idx;

   // pending stage
   logic          pend_ff;
   status_type    pend_status_ff, pend_status_in;
   rd_sel_type    pend_rd_sel_ff, pend_rd_sel_in;
   logic [IW-1:0] pend_rd_idx_ff, pend_rd_idx_in;

   // output register
   logic          rsp_valid_ff;
   word_type      rsp_read_value_ff, rsp_first_ff, rsp_last_ff;
   logic [CW-1:0] rsp_count_ff;
   status_type    rsp_status_ff;

   logic          req_accept;
   logic          pend_move;
   logic [PW-1:0] pos_ext, cnt_ext;
   logic          is_full, is_empty;
   logic [IW-1:0] last_idx;
   word_type      rd_word;

   assign pend_move  = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = pend_ff && !pend_move;
   assign req_accept = req_valid && !req_stall;

   assign pos_ext  = PW'(req_position);
   assign cnt_ext  = PW'(count_ff);
   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);

   // command decode against the current count
   always_comb begin
      cell_ctl.op    = OP_HOLD;
      cell_ctl.value = req_value;
      at_idx         = CW'(pos_ext);
      count_in       = count_ff;
      pend_status_in = ST_OK;
      pend_rd_sel_in = RD_ZERO;
      pend_rd_idx_in = IW'(pos_ext);
      if (req_accept) begin
         unique case (req_cmd)
            CMD_INSERT: begin
               if (is_full) begin
                  pend_status_in = ST_FULL;
               end else if (pos_ext > cnt_ext) begin
                  pend_status_in = ST_RANGE;
               end else begin
                  cell_ctl.op = OP_INSERT;
                  count_in    = CW'(count_ff + 1'b1);
               end
            end
            CMD_REMOVE: begin
               if (is_empty) begin
                  pend_status_in = ST_EMPTY;
               end else if (pos_ext >= cnt_ext) begin
                  pend_status_in = ST_RANGE;
               end else begin
                  cell_ctl.op = OP_REMOVE;
                  count_in    = CW'(count_ff - 1'b1);
               end
            end
            CMD_READ: begin
               if (pos_ext < cnt_ext) begin
                  pend_rd_sel_in = RD_WORD;
               end else begin
                  pend_rd_sel_in = RD_MIN;
                  pend_status_in = ST_RANGE;
               end
            end
            CMD_PUSH: begin
               if (is_full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  cell_ctl.op = OP_INSERT;
                  at_idx      = count_ff;
                  count_in    = CW'(count_ff + 1'b1);
               end
            end
            CMD_POP: begin
               if (is_empty) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  count_in = CW'(count_ff - 1'b1);
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_w, right_w;
      if (i == 0) begin : g_lo
         assign left_w = '0;
      end else begin : g_lo
         assign left_w = words[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi
         assign right_w = '0;
      end else begin : g_hi
         assign right_w = words[i+1];
      end
      iidl_cell #(
         .CNT_W (CW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .at_idx     (at_idx),
         .cnt        (count_ff),
         .left_word  (left_w),
         .right_word (right_w),
         .word_out   (words[i])
      );
   end

   // result selection from the updated chain
   assign last_idx = IW'(count_ff - 1'b1);

   always_comb begin
      unique case (pend_rd_sel_ff)
         RD_WORD: rd_word = words[pend_rd_idx_ff];
         RD_MIN:  rd_word = MOST_NEG;
         default: rd_word = '0;
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_accept) begin
            pend_ff <= 1'b1;
         end else if (pend_move) begin
            pend_ff <= 1'b0;
         end
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= pend_ff;
         end
      end
      if (req_accept) begin
         pend_status_ff <= pend_status_in;
         pend_rd_sel_ff <= pend_rd_sel_in;
         pend_rd_idx_ff <= pend_rd_idx_in;
      end
      if (pend_move) begin
         rsp_read_value_ff <= rd_word;
         rsp_count_ff      <= count_ff;
         rsp_first_ff      <= (count_ff != '0) ? words[0] : '0;
         rsp_last_ff       <= (count_ff != '0) ? words[last_idx] : '0;
         rsp_status_ff     <= pend_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_count       = COUNT_W'(rsp_count_ff);
   assign rsp_first_entry = rsp_first_ff;
   assign rsp_last_entry  = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== rtl/core/iidl_checker.sv =====
// ----------------------------------------------------------------------------
// iidl_checker
// Port-level checks on the list's results, bound to the top level.
// ----------------------------------------------------------------------------
module iidl_checker #(
   parameter int DEPTH = iidl_pkg::DEPTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [iidl_pkg::VALUE_W-1:0] rsp_read_value,
   input logic [iidl_pkg::COUNT_W-1:0]   rsp_count,
   input logic signed [iidl_pkg::VALUE_W-1:0] rsp_first_entry,
   input logic signed [iidl_pkg::VALUE_W-1:0] rsp_last_entry,
   input logic [iidl_pkg::STATUS_W-1:0]  rsp_status
);
   import iidl_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_OUT = COUNT_W'(DEPTH);

   // an empty list shows zero first and last entries
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == '0) |-> (rsp_first_entry == '0 && rsp_last_entry == '0))
      else $error("empty list with nonzero first/last entry");

   // full status only with the list at depth
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_count == FULL_OUT))
      else $error("full status with count below depth");

   // empty status only with an empty list and a zero read value, as after remove or pop
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_count == '0 && rsp_read_value == '0))
      else $error("empty status with entries present");

   // count never exceeds depth while it fits the field
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && DEPTH < 128) |-> (rsp_count <= FULL_OUT))
      else $error("count above depth");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_count) && $stable(rsp_status)))
      else $error("stalled result beat changed");

endmodule

bind indexed_insert_delete_list iidl_checker #(.DEPTH(DEPTH)) u_iidl_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for indexed_insert_delete_list. Commands go in through
// the req channel with random idle gaps, and the rsp channel stalls at random.
// A local copy of the list predicts every result beat. Directed sequences
// cover the empty and full list, range errors, spare command codes and value
// extremes. Random growing and shrinking sequences then fill and drain the
// list many times over.
// ----------------------------------------------------------------------------
module testbench;
   import iidl_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEF;
   localparam int STALL_LIMIT = 100;
   localparam int SETTLE_CYCLES = 4;

   // codes outside the command set: the block must treat them as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   localparam word_type MOST_POS = 32'sh7fff_ffff;

   typedef struct {
      word_type               read_value;
      logic [COUNT_W-1:0]     count;
      word_type               first_entry;
      word_type               last_entry;
      status_type             status;
   } list_reply_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [CMD_W-1:0]       req_cmd = '0;
   logic [POS_W-1:0]       req_position = '0;
   word_type               req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   word_type               rsp_read_value;
   logic [COUNT_W-1:0]     rsp_count;
   word_type               rsp_first_entry;
   word_type               rsp_last_entry;
   logic [STATUS_W-1:0]    rsp_status;

   // shadow copy of the list
   word_type               list_words [LIST_DEPTH];
   int                     list_count = 0;
   list_reply_type         expected_replies [$];

   bit                     idle_on = 1'b1;
   int                     error_count = 0;
   int                     commands_sent = 0;
   int                     replies_checked = 0;
   int                     full_hits = 0;
   int                     quiet_cycles = 0;
   int                     stall_left = 0;

   indexed_insert_delete_list #(
      .DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_value(rsp_read_value),
      .rsp_count(rsp_count),
      .rsp_first_entry(rsp_first_entry),
      .rsp_last_entry(rsp_last_entry),
      .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one command to the shadow list and return the reply it must give
   function automatic list_reply_type apply_list_command(logic [CMD_W-1:0] cmd,
                                                         logic [POS_W-1:0] pos,
                                                         word_type value);
      list_reply_type reply;
      int             at;
      at = pos;
      reply.read_value = '0;
      reply.status = ST_OK;
      case (cmd)
         CMD_INSERT: begin
            if (list_count >= LIST_DEPTH) begin
               reply.status = ST_FULL;
            end else if (at > list_count) begin
               reply.status = ST_RANGE;
            end else begin
               for (int i = list_count; i > at; i--) list_words[i] = list_words[i-1];
               list_words[at] = value;
               list_count++;
            end
         end
         CMD_REMOVE: begin
            if (list_count == 0) begin
               reply.status = ST_EMPTY;
            end else if (at >= list_count) begin
               reply.status = ST_RANGE;
            end else begin
               for (int i = at; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         CMD_READ: begin
            if (at < list_count) begin
               reply.read_value = list_words[at];
            end else begin
               reply.read_value = MOST_NEG;
               reply.status = ST_RANGE;
            end
         end
         CMD_PUSH: begin
            if (list_count >= LIST_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               list_words[list_count] = value;
               list_count++;
            end
         end
         CMD_POP: begin
            if (list_count == 0) reply.status = ST_EMPTY;
            else list_count--;
         end
         CMD_CLEAR: begin
            list_count = 0;
         end
         default: begin
         end
      endcase
      reply.count = list_count[COUNT_W-1:0];
      if (list_count > 0) begin
         reply.first_entry = list_words[0];
         reply.last_entry = list_words[list_count-1];
      end else begin
         reply.first_entry = '0;
         reply.last_entry = '0;
      end
      return reply;
   endfunction

   // random word, leaning on the extremes now and then
   function automatic word_type pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return MOST_NEG;
         1: return MOST_POS;
         2: return '0;
         3: return -32'sd1;
         default: return word_type'($urandom);
      endcase
   endfunction

   // drive one command beat, hold it until taken, then record its reply
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input word_type value);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_position <= pos;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_replies.push_back(apply_list_command(cmd, pos, value));
      commands_sent++;
   endtask

   task automatic wait_for_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   // result side: random stall bursts, none once idling is switched off
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare every result beat with the oldest prediction
   always @(posedge clock) begin : check_reply
      list_reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         replies_checked++;
         if (expected_replies.size() == 0) begin
            $error("result beat with no command outstanding");
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (want.status == ST_FULL) full_hits++;
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               error_count++;
            end
            if (rsp_first_entry !== want.first_entry) begin
               $error("first_entry: expected %0d, got %0d", want.first_entry,
                      rsp_first_entry);
               error_count++;
            end
            if (rsp_last_entry !== want.last_entry) begin
               $error("last_entry: expected %0d, got %0d", want.last_entry, rsp_last_entry);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_replies.size());
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // empty list: range and empty errors, spare codes, clear
   task automatic test_empty_list();
      send_command(CMD_READ, 7'd0, '0);
      send_command(CMD_READ, 7'd127, '0);
      send_command(CMD_REMOVE, 7'd0, '0);
      send_command(CMD_POP, 7'd0, '0);
      send_command(CMD_SPARE_A, 7'd5, MOST_POS);
      send_command(CMD_SPARE_B, 7'd127, MOST_NEG);
      send_command(CMD_CLEAR, 7'd0, '0);
   endtask

   // insert, append, past-end insert, reads and removes at the borders
   task automatic test_boundary_values();
      send_command(CMD_PUSH, 7'd0, MOST_POS);
      send_command(CMD_INSERT, 7'd0, MOST_NEG);
      send_command(CMD_INSERT, 7'd2, -32'sd1);
      send_command(CMD_INSERT, 7'd4, '0);
      send_command(CMD_READ, 7'd0, '0);
      send_command(CMD_READ, 7'd2, '0);
      send_command(CMD_READ, 7'd3, '0);
      send_command(CMD_REMOVE, 7'd1, '0);
      send_command(CMD_REMOVE, 7'd2, '0);
      send_command(CMD_INSERT, 7'd127, 32'sh1234_5678);
      send_command(CMD_SPARE_A, 7'd0, '0);
      send_command(CMD_POP, 7'd0, '0);
      send_command(CMD_PUSH, 7'd0, 32'sh5555_aaaa);
      send_command(CMD_CLEAR, 7'd0, '0);
   endtask

   // fill to capacity, hit every full case, then drain past empty
   task automatic test_full_list();
      while (list_count < LIST_DEPTH) begin
         if ($urandom_range(0, 1) == 0) send_command(CMD_PUSH, 7'd0, pick_value());
         else send_command(CMD_INSERT, POS_W'($urandom_range(0, list_count)), pick_value());
      end
      send_command(CMD_INSERT, 7'd0, pick_value());
      send_command(CMD_INSERT, 7'd127, pick_value());
      send_command(CMD_PUSH, 7'd0, pick_value());
      send_command(CMD_READ, POS_W'(LIST_DEPTH - 1), '0);
      send_command(CMD_READ, POS_W'(LIST_DEPTH), '0);
      send_command(CMD_REMOVE, POS_W'(LIST_DEPTH - 1), '0);
      send_command(CMD_INSERT, POS_W'(LIST_DEPTH - 1), pick_value());
      send_command(CMD_REMOVE, 7'd0, '0);
      send_command(CMD_INSERT, 7'd0, pick_value());
      while (list_count > 0) begin
         if ($urandom_range(0, 1) == 0) send_command(CMD_POP, 7'd0, '0);
         else send_command(CMD_REMOVE, POS_W'($urandom_range(0, list_count - 1)), '0);
      end
      send_command(CMD_POP, 7'd0, '0);
   endtask

   // random growing and shrinking runs, with a little noise mixed in
   task automatic test_random_commands(input int num);
      bit               grow;
      int               r;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      grow = 1'b1;
      for (int n = 0; n < num; n++) begin
         if (list_count >= LIST_DEPTH) grow = 1'b0;
         else if (list_count == 0) grow = 1'b1;
         else if ($urandom_range(0, 79) == 0) grow = !grow;
         r = $urandom_range(0, 99);
         if (r < 5) begin
            send_command(CMD_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 127)),
                         pick_value());
         end else begin
            r = $urandom_range(0, 99);
            if (grow) begin
               if (r < 35) cmd = CMD_INSERT;
               else if (r < 55) cmd = CMD_PUSH;
               else if (r < 65) cmd = CMD_REMOVE;
               else if (r < 70) cmd = CMD_POP;
               else if (r < 99) cmd = CMD_READ;
               else cmd = CMD_CLEAR;
            end else begin
               if (r < 10) cmd = CMD_INSERT;
               else if (r < 15) cmd = CMD_PUSH;
               else if (r < 50) cmd = CMD_REMOVE;
               else if (r < 70) cmd = CMD_POP;
               else if (r < 99) cmd = CMD_READ;
               else cmd = CMD_CLEAR;
            end
            // mostly legal positions, now and then anywhere
            if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 127));
            else if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(0, list_count));
            else if (list_count > 0) pos = POS_W'($urandom_range(0, list_count - 1));
            else pos = POS_W'($urandom_range(0, 127));
            send_command(cmd, pos, pick_value());
         end
      end
   endtask

   // sender holds off until every outstanding result is back
   task automatic test_drain_pause();
      wait_for_replies();
      send_command(CMD_READ, 7'd0, '0);
   endtask

   // back-to-back beats with no idling on either side
   task automatic test_steady_stream();
      idle_on = 1'b0;
      test_random_commands(150);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_boundary_values();
      test_full_list();
      test_random_commands(425);
      test_drain_pause();
      test_random_commands(425);
      test_steady_stream();

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0) begin
         $error("%0d results never arrived", expected_replies.size());
         error_count++;
      end
      $display("ran %0d commands, checked %0d results, %0d of them full-list rejects",
               commands_sent, replies_checked, full_hits);
      $display("errors seen: %0d", error_count);
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
